[rtl/xml_attribute_escaper_top_macros.svh]
// Assertion macros used by the XML attribute escaper top level.
// Each macro expects signals named clk and rst in the scope of its use.
`ifndef XML_ATTRIBUTE_ESCAPER_TOP_MACROS_SVH
`define XML_ATTRIBUTE_ESCAPER_TOP_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define XAE_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define XAE_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/xae_pkg.sv]
// Package for the XML attribute escaper: payload types, escape kinds and the
// tables that turn a kind into its output bytes. No dependencies.
package xae_pkg;

  localparam int XAE_QUEUE_DEPTH = 4;

  typedef logic [2:0] kind_t;

  localparam kind_t KIND_PASS = 3'd0;
  localparam kind_t KIND_LT   = 3'd1;
  localparam kind_t KIND_AMP  = 3'd2;
  localparam kind_t KIND_GT   = 3'd3;
  localparam kind_t KIND_APOS = 3'd4;
  localparam kind_t KIND_QUOT = 3'd5;
  localparam kind_t KIND_HEX  = 3'd6;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       string_end;
  } in_item_t;

  typedef struct packed {
    logic [7:0]  out_byte;
    logic        run_last;
    logic        string_done;
    logic [31:0] escaped_length;
  } out_item_t;

  typedef struct packed {
    logic [7:0] raw_byte;
    logic       string_end;
    kind_t      kind;
  } queue_item_t;

  // Number of output bytes produced for one input of the given kind.
  function automatic logic [2:0] esc_len(input kind_t kind);
    logic [2:0] len;
    unique case (kind)
      KIND_PASS: len = 3'd1;
      KIND_LT:   len = 3'd4;
      KIND_AMP:  len = 3'd5;
      KIND_GT:   len = 3'd4;
      KIND_APOS: len = 3'd6;
      KIND_QUOT: len = 3'd6;
      KIND_HEX:  len = 3'd6;
      default:   len = 3'd1;
    endcase
    return len;
  endfunction

  function automatic logic [7:0] hex_digit(input logic [3:0] nib);
    logic [7:0] d;
    if (nib < 4'd10) d = 8'h30 + {4'd0, nib};
    else             d = 8'h61 + {4'd0, nib} - 8'd10;
    return d;
  endfunction

  // Output byte at position idx of the escape sequence for one input.
  function automatic logic [7:0] esc_char(input kind_t kind, input logic [7:0] raw,
                                          input logic [2:0] idx);
    logic [7:0] ch;
    ch = 8'h3b;
    unique case (kind)
      KIND_PASS: ch = raw;
      KIND_LT: begin
        case (idx)
          3'd0:    ch = 8'h26;
          3'd1:    ch = 8'h6c;
          3'd2:    ch = 8'h74;
          default: ch = 8'h3b;
        endcase
      end
      KIND_AMP: begin
        case (idx)
          3'd0:    ch = 8'h26;
          3'd1:    ch = 8'h61;
          3'd2:    ch = 8'h6d;
          3'd3:    ch = 8'h70;
          default: ch = 8'h3b;
        endcase
      end
      KIND_GT: begin
        case (idx)
          3'd0:    ch = 8'h26;
          3'd1:    ch = 8'h67;
          3'd2:    ch = 8'h74;
          default: ch = 8'h3b;
        endcase
      end
      KIND_APOS: begin
        case (idx)
          3'd0:    ch = 8'h26;
          3'd1:    ch = 8'h61;
          3'd2:    ch = 8'h70;
          3'd3:    ch = 8'h6f;
          3'd4:    ch = 8'h73;
          default: ch = 8'h3b;
        endcase
      end
      KIND_QUOT: begin
        case (idx)
          3'd0:    ch = 8'h26;
          3'd1:    ch = 8'h71;
          3'd2:    ch = 8'h75;
          3'd3:    ch = 8'h6f;
          3'd4:    ch = 8'h74;
          default: ch = 8'h3b;
        endcase
      end
      KIND_HEX: begin
        case (idx)
          3'd0:    ch = 8'h26;
          3'd1:    ch = 8'h23;
          3'd2:    ch = 8'h78;
          3'd3:    ch = hex_digit(raw[7:4]);
          3'd4:    ch = hex_digit(raw[3:0]);
          default: ch = 8'h3b;
        endcase
      end
      default: ch = raw;
    endcase
    return ch;
  endfunction

endpackage

[rtl/xml_attribute_escaper_top.sv]
// XML attribute escaper, top level. An input transfer is stored in the queue and
// its first output byte is then registered in the back end. The back end emits
// one output byte per cycle while out_stall is low; a plain byte gives one output
// byte, an escape 4 to 6. The input stalls only when the queue in between is full.
// Reset (rst, synchronous) empties the queue, drops out_valid and zeroes the
// running count. Depends on xae_pkg, xae_front, xae_queue, xae_back.
`include "xml_attribute_escaper_top_macros.svh"

module xml_attribute_escaper_top
  import xae_pkg::*;
#(
  parameter int QueueDepth = XAE_QUEUE_DEPTH
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  logic        q_full;
  logic        push_valid;
  queue_item_t push_item;
  logic        head_valid;
  queue_item_t head_item;
  logic        q_pop;

  xae_front u_front (
    .in_valid   (in_valid),
    .in_data    (in_data),
    .in_stall   (in_stall),
    .q_full     (q_full),
    .push_valid (push_valid),
    .push_item  (push_item)
  );

  xae_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push_valid),
    .push_item  (push_item),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (head_valid),
    .head_item  (head_item)
  );

  xae_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head_item  (head_item),
    .pop        (q_pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data)
  );

  `XAE_ASSERT_NOW(a_done_ends_run, out_valid && out_data.string_done, out_data.run_last, "string_done without run_last")
  `XAE_ASSERT_NEXT(a_pop_shows_run_end, q_pop, out_valid && out_data.run_last, "queue pop did not present a run end")
  `XAE_ASSERT_NOW(a_done_length, out_valid && out_data.string_done, out_data.escaped_length >= 32'd2, "final length too small")

endmodule

[rtl/xae_front.sv]
// Front end of the XML attribute escaper: accepts input transfers and tags
// each byte with its escape kind. Depends on xae_pkg.
module xae_front
  import xae_pkg::*;
(
  input  logic        in_valid,
  input  in_item_t    in_data,
  output logic        in_stall,
  input  logic        q_full,
  output logic        push_valid,
  output queue_item_t push_item
);

  function automatic kind_t classify(input logic [7:0] c);
    kind_t k;
    unique case (c)
      8'h3c:   k = KIND_LT;
      8'h26:   k = KIND_AMP;
      8'h3e:   k = KIND_GT;
      8'h27:   k = KIND_APOS;
      8'h22:   k = KIND_QUOT;
      default: begin
        // Control bytes other than tab and line feed, and DEL, go out as hex.
        if ((c < 8'h20 && c != 8'h09 && c != 8'h0a) || c == 8'h7f) k = KIND_HEX;
        else k = KIND_PASS;
      end
    endcase
    return k;
  endfunction

  assign in_stall             = q_full;
  assign push_valid           = in_valid && !q_full;
  assign push_item.raw_byte   = in_data.in_byte;
  assign push_item.string_end = in_data.string_end;
  assign push_item.kind       = classify(in_data.in_byte);

endmodule

[rtl/xae_queue.sv]
// Small register queue between the escaper's front and back ends.
// Depends on xae_pkg for the entry type.
module xae_queue
  import xae_pkg::*;
#(
  parameter int Depth = XAE_QUEUE_DEPTH
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  input  queue_item_t push_item,
  output logic        full,
  input  logic        pop,
  output logic        head_valid,
  output queue_item_t head_item
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  queue_item_t         entries [Depth];
  logic [PtrW-1:0]     wr_ptr;
  logic [PtrW-1:0]     rd_ptr;
  logic [CntW-1:0]     count;
  logic                do_push;
  logic                do_pop;

  assign full       = (count == FullCnt);
  assign head_valid = (count != '0);
  assign head_item  = entries[rd_ptr];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (do_push) entries[wr_ptr] <= push_item;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= (wr_ptr == LastPtr) ? '0 : wr_ptr + 1'b1;
      if (do_pop)  rd_ptr <= (rd_ptr == LastPtr) ? '0 : rd_ptr + 1'b1;
      if (do_push && !do_pop)      count <= count + 1'b1;
      else if (!do_push && do_pop) count <= count - 1'b1;
    end
  end

endmodule

[rtl/xae_back.sv]
// Back end of the XML attribute escaper: expands each queued byte into its
// escape sequence, one byte per cycle while out_stall is low, and keeps the
// running count. Depends on xae_pkg.
module xae_back
  import xae_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        head_valid,
  input  queue_item_t head_item,
  output logic        pop,
  output logic        out_valid,
  input  logic        out_stall,
  output out_item_t   out_data
);

  logic [2:0]  idx;
  logic [31:0] count;
  logic        load;
  logic [2:0]  run_len;
  logic        run_end;
  logic        done;
  logic [31:0] count_inc;
  logic [31:0] len_report;

  assign run_len    = esc_len(head_item.kind);
  assign run_end    = (idx == 3'(run_len - 3'd1));
  assign done       = run_end && head_item.string_end;
  assign load       = head_valid && (!out_valid || !out_stall);
  assign pop        = load && run_end;
  assign count_inc  = (count == '1) ? count : count + 32'd1;
  // The string's final byte also counts the terminator.
  assign len_report = (done && count_inc != '1) ? count_inc + 32'd1 : count_inc;

  always_ff @(posedge clk) begin
    if (rst) begin
      idx       <= '0;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (!out_valid || !out_stall) out_valid <= head_valid;
      if (load) begin
        idx   <= run_end ? 3'd0 : idx + 3'd1;
        count <= done ? 32'd0 : count_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_data.out_byte       <= esc_char(head_item.kind, head_item.raw_byte, idx);
      out_data.run_last       <= run_end;
      out_data.string_done    <= done;
      out_data.escaped_length <= len_report;
    end
  end

endmodule
